// ===== rtl/gedf_pkg.sv =====
// Shared types and constants for the G-EDF CPU placement table.
`timescale 1ns / 1ps

package gedf_pkg;

	localparam int CPU_COUNT_DEF = 16;  // default number of table entries
	localparam int MASK_W        = 16;  // online mask width
	localparam int CPU_W         = 4;   // cpu / target_cpu field width
	localparam int PID_W         = 22;
	localparam int DL_W          = 64;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_PLACE  = 1'b1;

	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [DL_W-1:0]  deadline;
	} gedf_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_READ,
		ST_DECIDE,
		ST_RESULT
	} gedf_state_t;

endpackage

// ===== rtl/gedf_if.sv =====
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps

interface gedf_req_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [gedf_pkg::CPU_W-1:0]   cpu;
	logic                         linked_valid;
	logic [gedf_pkg::PID_W-1:0]   job_pid;
	logic [gedf_pkg::DL_W-1:0]    job_deadline;

	modport source (output valid, func, cpu, linked_valid, job_pid, job_deadline,
		input ready);
	modport sink (input valid, func, cpu, linked_valid, job_pid, job_deadline,
		output ready);
endinterface

interface gedf_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [gedf_pkg::CPU_W-1:0]   target_cpu;
	logic                         should_preempt;
	logic                         no_cpu_online;

	modport source (output valid, target_cpu, should_preempt, no_cpu_online,
		input ready);
	modport sink (input valid, target_cpu, should_preempt, no_cpu_online,
		output ready);
endinterface

interface gedf_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [gedf_pkg::MASK_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/gedf_cpu_placement_table_core.sv =====
// Top level of the G-EDF CPU placement table.
`timescale 1ns / 1ps

// Per-CPU placement table for a global EDF scheduler. Update items (func 0)
// mark a CPU idle or record the deadline and PID of the job linked to it, and
// return an all-zero item. Place items (func 1) walk the online CPUs in
// rotating order from the search start. The walk reads one table entry per
// cycle through a single read port and uses one shared 64-bit subtractor.
// The first idle CPU wins; otherwise the CPU whose job has the latest deadline
// wins, with the higher PID winning a tie. The response says whether the
// offered task should preempt that CPU. An update goes straight to the result
// step. A placement that reuses the cached minimum skips the walk and goes to
// the read step. A full search does one table read per CPU, then a drain,
// pick, read, decide and result step. A hit on an idle CPU ends the walk early
// and goes to the read step. When no CPU is online, no_cpu_online is set with
// target_cpu 0. The table accepts a new request while the previous response
// still waits on the output register. A response that is still blocked holds
// the block in its result step. Writing online_mask (always ready) drops the
// cached minimum; write it only while the block is idle. Entries are reset by
// per-CPU valid bits, so no clearing pass is needed after reset.

module gedf_cpu_placement_table_core #(
	parameter int CPU_COUNT = gedf_pkg::CPU_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gedf_req_if.sink   req,
	gedf_rsp_if.source rsp,
	gedf_cfg_if.sink   cfg
);

	localparam int CW = $clog2(CPU_COUNT);
	localparam int EW = $bits(gedf_pkg::gedf_entry_t);

	gedf_pkg::gedf_state_t state_q, state_d;

	// configuration and per-CPU control state
	logic [gedf_pkg::MASK_W-1:0] mask_q;
	logic [CPU_COUNT-1:0]        idle_q;
	logic [CPU_COUNT-1:0]        ent_vld_q;
	logic [CPU_COUNT-1:0]        online_vec;
	logic [CPU_COUNT-1:0]        idle_vec;
	logic [CW-1:0]               search_q;
	logic                        cached_q;

	// task under placement
	logic [gedf_pkg::PID_W-1:0]  task_pid_q;
	logic [gedf_pkg::DL_W-1:0]   task_dl_q;

	// scan position and running best candidate
	logic [CW-1:0]               pos_q;
	logic [CW-1:0]               pos_nxt;
	logic [CW-1:0]               cnt_q;
	logic                        have_online_q;
	logic [CW-1:0]               tgt_q;
	logic                        tgt_vld_q;
	logic [gedf_pkg::PID_W-1:0]  tgt_pid_q;
	logic [gedf_pkg::DL_W-1:0]   tgt_dl_q;

	// compare stage, in the cycle after the table read
	logic                        cmp_vld_s1;
	logic [CW-1:0]               cmp_pos_s1;
	logic                        rvld_s1;

	// pending and delivered response
	logic [gedf_pkg::CPU_W-1:0]  res_tgt_q;
	logic                        res_pre_q;
	logic                        res_none_q;
	logic                        out_vld_q;
	logic [gedf_pkg::CPU_W-1:0]  out_tgt_q;
	logic                        out_pre_q;
	logic                        out_none_q;

	// table memory
	logic                        ram_we;
	logic [CW-1:0]               ram_waddr;
	logic [CW-1:0]               ram_raddr;
	gedf_pkg::gedf_entry_t       ram_wdata;
	logic [EW-1:0]               ram_rdata;
	gedf_pkg::gedf_entry_t       ent;

	// shared subtractor
	logic [gedf_pkg::DL_W-1:0]   sub_a;
	logic [gedf_pkg::DL_W-1:0]   sub_b;
	logic [gedf_pkg::DL_W-1:0]   sub_d;
	logic                        sub_neg;
	logic                        sub_zero;
	logic                        lower_prio;
	logic                        preempt;

	logic                        req_acc;
	logic                        upd_acc;
	logic                        upd_ok;
	logic [CW-1:0]               upd_idx;
	logic                        pos_on;
	logic                        pos_idle;
	logic                        out_free;

	// CPUs at or above the mask width are never online
	for (genvar i = 0; i < CPU_COUNT; i++) begin : g_online
		if (i < gedf_pkg::MASK_W) begin : g_in
			assign online_vec[i] = mask_q[i];
		end else begin : g_out
			assign online_vec[i] = 1'b0;
		end
	end
	assign idle_vec = online_vec & idle_q;

	assign req_acc  = req.valid && req.ready;
	assign upd_ok   = 32'(req.cpu) < CPU_COUNT;
	assign upd_acc  = req_acc && (req.func == gedf_pkg::FUNC_UPDATE) && upd_ok;
	assign upd_idx  = CW'(req.cpu);
	assign pos_on   = online_vec[pos_q];
	assign pos_idle = idle_vec[pos_q];
	assign pos_nxt  = (pos_q == CW'(CPU_COUNT - 1)) ? '0 : pos_q + CW'(1);
	assign out_free = !out_vld_q || rsp.ready;

	assign ram_we             = upd_acc && req.linked_valid;
	assign ram_waddr          = upd_idx;
	assign ram_wdata.pid      = req.job_pid;
	assign ram_wdata.deadline = req.job_deadline;

	gedf_ram #(
		.WIDTH(EW),
		.DEPTH(CPU_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// entries never written read as zero
	assign ent = rvld_s1 ? gedf_pkg::gedf_entry_t'(ram_rdata) : '0;

	// one wrap-aware deadline subtractor: candidate vs best while scanning,
	// task vs target entry in the decision step
	assign sub_a    = (state_q == gedf_pkg::ST_DECIDE) ? task_dl_q : ent.deadline;
	assign sub_b    = (state_q == gedf_pkg::ST_DECIDE) ? ent.deadline : tgt_dl_q;
	assign sub_d    = sub_a - sub_b;
	assign sub_neg  = sub_d[gedf_pkg::DL_W-1];
	assign sub_zero = (sub_d == '0);

	// candidate deadline later, or equal with higher PID
	assign lower_prio = (!sub_zero && !sub_neg) || (sub_zero && (ent.pid > tgt_pid_q));
	// target idle, task deadline earlier, or equal with lower PID
	assign preempt    = idle_vec[tgt_q] || sub_neg || (sub_zero && (task_pid_q < ent.pid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gedf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		ram_raddr = tgt_q;
		unique case (state_q)
			gedf_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.func == gedf_pkg::FUNC_UPDATE) begin
						state_d = gedf_pkg::ST_RESULT;
					end else if (cached_q) begin
						state_d = gedf_pkg::ST_READ;
					end else begin
						state_d = gedf_pkg::ST_SCAN;
					end
				end
			end
			gedf_pkg::ST_SCAN: begin
				ram_raddr = pos_q;
				if (pos_idle) begin
					state_d = gedf_pkg::ST_READ;
				end else if (cnt_q == CW'(CPU_COUNT - 1)) begin
					state_d = gedf_pkg::ST_DRAIN;
				end
			end
			gedf_pkg::ST_DRAIN:  state_d = gedf_pkg::ST_PICK;
			gedf_pkg::ST_PICK: begin
				state_d = have_online_q ? gedf_pkg::ST_READ : gedf_pkg::ST_RESULT;
			end
			gedf_pkg::ST_READ:   state_d = gedf_pkg::ST_DECIDE;
			gedf_pkg::ST_DECIDE: state_d = gedf_pkg::ST_RESULT;
			gedf_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = gedf_pkg::ST_IDLE;
				end
			end
			default: state_d = gedf_pkg::ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q        <= '0;
			idle_q        <= '1;
			ent_vld_q     <= '0;
			search_q      <= '0;
			cached_q      <= 1'b0;
			have_online_q <= 1'b0;
			tgt_vld_q     <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mask_q <= cfg.data;
			end

			if (upd_acc) begin
				if (req.linked_valid) begin
					idle_q[upd_idx]    <= 1'b0;
					ent_vld_q[upd_idx] <= 1'b1;
				end else begin
					idle_q[upd_idx] <= 1'b1;
					search_q        <= upd_idx;
				end
			end

			if (req_acc && (req.func == gedf_pkg::FUNC_PLACE)) begin
				have_online_q <= 1'b0;
				tgt_vld_q     <= 1'b0;
			end

			// compare stage
			cmp_vld_s1 <= (state_q == gedf_pkg::ST_SCAN) && pos_on && !pos_idle;
			if (cmp_vld_s1 && (!tgt_vld_q || lower_prio)) begin
				tgt_vld_q <= 1'b1;
			end

			if (state_q == gedf_pkg::ST_SCAN) begin
				if (pos_on) begin
					have_online_q <= 1'b1;
				end
				if (pos_idle) begin
					search_q <= pos_q;
				end
			end

			if ((state_q == gedf_pkg::ST_PICK) && have_online_q) begin
				search_q <= tgt_q;
			end

			// cached minimum: dropped by a mask write or an update, set by a search
			if (cfg.valid || upd_acc) begin
				cached_q <= 1'b0;
			end else if ((state_q == gedf_pkg::ST_SCAN) && pos_idle) begin
				// idle hit: cache only if a busy online CPU came first
				cached_q <= have_online_q;
			end else if ((state_q == gedf_pkg::ST_PICK) && have_online_q) begin
				cached_q <= 1'b1;
			end

			if ((state_q == gedf_pkg::ST_RESULT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		rvld_s1    <= ent_vld_q[ram_raddr];
		cmp_pos_s1 <= pos_q;

		if (req_acc) begin
			task_pid_q <= req.job_pid;
			task_dl_q  <= req.job_deadline;
			pos_q      <= search_q;
			cnt_q      <= '0;
			tgt_q      <= search_q;
			res_tgt_q  <= '0;
			res_pre_q  <= 1'b0;
			res_none_q <= 1'b0;
		end

		if (state_q == gedf_pkg::ST_SCAN) begin
			pos_q <= pos_nxt;
			cnt_q <= cnt_q + CW'(1);
		end

		// an idle hit overrides any compare still in flight
		if ((state_q == gedf_pkg::ST_SCAN) && pos_idle) begin
			tgt_q <= pos_q;
		end else if (cmp_vld_s1 && (!tgt_vld_q || lower_prio)) begin
			tgt_q     <= cmp_pos_s1;
			tgt_pid_q <= ent.pid;
			tgt_dl_q  <= ent.deadline;
		end

		if ((state_q == gedf_pkg::ST_PICK) && !have_online_q) begin
			res_none_q <= 1'b1;
		end

		if (state_q == gedf_pkg::ST_DECIDE) begin
			res_tgt_q <= gedf_pkg::CPU_W'(tgt_q);
			res_pre_q <= preempt;
		end

		if ((state_q == gedf_pkg::ST_RESULT) && out_free) begin
			out_tgt_q  <= res_tgt_q;
			out_pre_q  <= res_pre_q;
			out_none_q <= res_none_q;
		end
	end

	assign cfg.ready          = 1'b1;
	assign rsp.valid          = out_vld_q;
	assign rsp.target_cpu     = out_tgt_q;
	assign rsp.should_preempt = out_pre_q;
	assign rsp.no_cpu_online  = out_none_q;

endmodule

// ===== rtl/gedf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gedf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
